>>> src/assert_macros.svh
// ---------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands used by the RTL, clocked on clk and idle in reset.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define LFP_ASSERT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define LFP_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> src/lfp_pkg.sv
// ---------------------------------------------------------------------------
// lfp_pkg
// Shared types, constants and default pattern table of the LED fade PWM core.
// ---------------------------------------------------------------------------
package lfp_pkg;

	localparam int CHANNELS_DEF      = 6;
	localparam int PATTERN_DEPTH_DEF = 16;
	localparam int LEVEL_BITS_DEF    = 16;

	localparam int CMD_W     = 2;
	localparam int IDX_IN_W  = 4;
	localparam int MASK_W    = 6;
	localparam int LED_W     = 6;
	localparam int POS_W     = 4;
	localparam int PERIOD_W  = 16;
	localparam int MIN_W     = 8;
	localparam int CFG_W     = 16;
	localparam int CFG_IDX_W = 3;
	localparam int DATA_W    = 16;

	localparam logic [PERIOD_W-1:0] PWM_PERIOD_RST       = 16'd1023;
	localparam logic [PERIOD_W-1:0] FRAME_INTERVAL_RST   = 16'd1;
	localparam logic [PERIOD_W-1:0] MAX_LEVEL_RST        = 16'd511;
	localparam logic [MIN_W-1:0]    MIN_LEVEL_RST        = 8'd1;
	localparam logic [PERIOD_W-1:0] PATTERN_INTERVAL_RST = 16'd1279;

	localparam int DEFAULT_COUNT = 12;

	typedef enum logic [CMD_W-1:0] {
		CMD_PWM_STEP    = 2'd0,
		CMD_FRAME_TICK  = 2'd1,
		CMD_WRITE_ENTRY = 2'd2,
		CMD_RESTART     = 2'd3
	} cmd_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_PWM_PERIOD       = 3'd0,
		REG_FRAME_INTERVAL   = 3'd1,
		REG_MAX_LEVEL        = 3'd2,
		REG_MIN_LEVEL        = 3'd3,
		REG_PATTERN_INTERVAL = 3'd4
	} reg_idx_t;

	// Pattern table view used by the fade step.
	typedef struct packed {
		logic [MASK_W-1:0] entry0;
		logic [MASK_W-1:0] next_mask;
		logic              next_end;
	} table_rd_t;

	// What the fade step did to the sequencer.
	typedef struct packed {
		logic advance;
		logic restart;
	} fade_ctl_t;

	function automatic logic [MASK_W-1:0] default_entry(input int i);
		logic [MASK_W-1:0] m;
		case (i)
			0:       m = 6'h09;
			1:       m = 6'h12;
			2:       m = 6'h24;
			3:       m = 6'h1B;
			4:       m = 6'h1E;
			5:       m = 6'h36;
			6:       m = 6'h2D;
			7:       m = 6'h3F;
			8:       m = 6'h21;
			9:       m = 6'h14;
			10:      m = 6'h0C;
			11:      m = 6'h33;
			default: m = '0;
		endcase
		return m;
	endfunction

endpackage

>>> src/lfp_pattern_table.sv
// ---------------------------------------------------------------------------
// lfp_pattern_table
// Pattern entry store with the look-ahead read of the entry after the
// current one and the end-of-sequence test.
// ---------------------------------------------------------------------------
module lfp_pattern_table #(
	parameter int PATTERN_DEPTH = lfp_pkg::PATTERN_DEPTH_DEF,
	parameter int IDX_W         = $clog2(PATTERN_DEPTH)
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          we,
	input  logic [lfp_pkg::IDX_IN_W-1:0]  wr_idx,
	input  logic [lfp_pkg::MASK_W-1:0]    wr_mask,
	input  logic [IDX_W-1:0]              rd_idx,
	output lfp_pkg::table_rd_t            rd
);

	logic [lfp_pkg::MASK_W-1:0] entry_q [PATTERN_DEPTH];
	logic [IDX_W:0]             next_idx;
	logic                       next_in_range;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < PATTERN_DEPTH; i++) begin
				entry_q[i] <= lfp_pkg::default_entry(i);
			end
		end else if (we && (32'(wr_idx) < PATTERN_DEPTH)) begin
			entry_q[IDX_W'(wr_idx)] <= wr_mask;
		end
	end

	always_comb begin
		next_idx      = {1'b0, rd_idx} + (IDX_W + 1)'(1);
		next_in_range = next_idx < (IDX_W + 1)'(PATTERN_DEPTH);
		rd.entry0     = entry_q[0];
		rd.next_mask  = next_in_range ? entry_q[next_idx[IDX_W-1:0]] : '0;
		// Stepping past the last entry or onto an empty one ends the sequence.
		rd.next_end   = !next_in_range || (rd.next_mask == '0);
	end

endmodule

>>> src/lfp_fade.sv
// ---------------------------------------------------------------------------
// lfp_fade
// One fade step over all channels, including the pattern advance and the
// restart that a channel reaching its minimum can trigger part-way through.
// ---------------------------------------------------------------------------
module lfp_fade #(
	parameter int CHANNELS   = lfp_pkg::CHANNELS_DEF,
	parameter int LEVEL_BITS = lfp_pkg::LEVEL_BITS_DEF
) (
	input  logic [LEVEL_BITS-1:0]       level [CHANNELS],
	input  logic [CHANNELS-1:0]         rising,
	input  logic [lfp_pkg::MASK_W-1:0]  active_mask,
	input  logic                        change_pending,
	input  logic [LEVEL_BITS-1:0]       lo,
	input  logic [LEVEL_BITS-1:0]       hi,
	input  lfp_pkg::table_rd_t          tbl,
	output logic [LEVEL_BITS-1:0]       level_nxt [CHANNELS],
	output logic [CHANNELS-1:0]         rising_nxt,
	output logic [lfp_pkg::MASK_W-1:0]  mask_nxt,
	output lfp_pkg::fade_ctl_t          ctl
);

	localparam logic [LEVEL_BITS-1:0] LevelTop = '1;

	function automatic void step(
		input  logic [LEVEL_BITS-1:0] lvl,
		input  logic                  up,
		input  logic                  en,
		input  logic [LEVEL_BITS-1:0] lo_v,
		input  logic [LEVEL_BITS-1:0] hi_v,
		output logic [LEVEL_BITS-1:0] lvl_o,
		output logic                  up_o
	);
		logic [LEVEL_BITS-1:0] t;
		lvl_o = lo_v;
		up_o  = up;
		if (en) begin
			if (up) begin
				t = (lvl < LevelTop) ? lvl + 1'b1 : lvl;
				if (t >= hi_v) begin
					lvl_o = hi_v;
					up_o  = 1'b0;
				end else begin
					lvl_o = t;
				end
			end else begin
				t = (lvl != '0) ? lvl - 1'b1 : lvl;
				if (t <= lo_v) begin
					lvl_o = lo_v;
					up_o  = 1'b1;
				end else begin
					lvl_o = t;
				end
			end
		end
	endfunction

	logic [CHANNELS-1:0]   en_a, en_b, en_r;
	logic [LEVEL_BITS-1:0] lvl_a [CHANNELS];
	logic [LEVEL_BITS-1:0] lvl_b [CHANNELS];
	logic [LEVEL_BITS-1:0] lvl_r [CHANNELS];
	logic [CHANNELS-1:0]   up_a, up_b, up_r;
	logic [CHANNELS-1:0]   hit_a;
	logic [CHANNELS:0]     seen;
	logic                  advance, restart;

	// Each channel is evaluated under the current mask, under the next entry's
	// mask, and from the restarted state under entry zero; the first channel
	// that reaches its minimum decides which applies to the channels after it.
	always_comb begin
		en_a = CHANNELS'(active_mask);
		en_b = CHANNELS'(tbl.next_mask);
		en_r = CHANNELS'(tbl.entry0);
		seen = '0;
		for (int j = 0; j < CHANNELS; j++) begin
			step(level[j], rising[j], en_a[j], lo, hi, lvl_a[j], up_a[j]);
			step(level[j], rising[j], en_b[j], lo, hi, lvl_b[j], up_b[j]);
			step(lo, 1'b0, en_r[j], lo, hi, lvl_r[j], up_r[j]);
			// A falling channel only turns to rising when it reaches the minimum.
			hit_a[j]  = !rising[j] && up_a[j];
			seen[j+1] = seen[j] | hit_a[j];
		end
		advance = change_pending && seen[CHANNELS];
		restart = advance && tbl.next_end;
		for (int j = 0; j < CHANNELS; j++) begin
			if (!advance || !seen[j]) begin
				level_nxt[j]  = restart ? lo : lvl_a[j];
				rising_nxt[j] = restart ? 1'b0 : up_a[j];
			end else if (restart) begin
				level_nxt[j]  = lvl_r[j];
				rising_nxt[j] = up_r[j];
			end else begin
				level_nxt[j]  = lvl_b[j];
				rising_nxt[j] = up_b[j];
			end
		end
		if (restart) begin
			mask_nxt = tbl.entry0;
		end else if (advance) begin
			mask_nxt = tbl.next_mask;
		end else begin
			mask_nxt = active_mask;
		end
		ctl.advance = advance;
		ctl.restart = restart;
	end

endmodule

>>> src/six_channel_led_fade_pwm_core.sv
// ---------------------------------------------------------------------------
// six_channel_led_fade_pwm_core
// Multichannel LED PWM with triangle fading and a pattern sequencer.
// ---------------------------------------------------------------------------
// Each command transfer (PWM step, frame tick, pattern entry write or restart)
// yields exactly one result transfer with the LED on bits and the active
// pattern position after the command. The block takes one command per clock
// while the output is not stalled: a command is held in an input register,
// its whole effect on the counters, levels and sequencer is worked out in
// that cycle, and the result lands in an output register, so a result passes
// through both, and a stalled output only holds the pipe back once both are
// full. The pattern table comes out of reset with the default sequence loaded.
`include "assert_macros.svh"

module six_channel_led_fade_pwm_core #(
	parameter int CHANNELS      = lfp_pkg::CHANNELS_DEF,
	parameter int PATTERN_DEPTH = lfp_pkg::PATTERN_DEPTH_DEF,
	parameter int LEVEL_BITS    = lfp_pkg::LEVEL_BITS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	input  logic [lfp_pkg::DATA_W-1:0]     s_tdata,  // entry_index[3:0], entry_mask[9:4]
	input  logic [lfp_pkg::CMD_W-1:0]      s_tuser,  // cmd[1:0]
	output logic                           m_tvalid,
	input  logic                           m_tready,
	output logic [lfp_pkg::DATA_W-1:0]     m_tdata,  // led_on[5:0], pattern_position[9:6]
	input  logic                           cfg_we,
	input  logic [lfp_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [lfp_pkg::CFG_W-1:0]      cfg_data
);

	localparam int IDX_W = $clog2(PATTERN_DEPTH);
	localparam int PW    = lfp_pkg::PERIOD_W;
	localparam logic [PW-1:0] LevelTop = PW'((33'd1 << LEVEL_BITS) - 33'd1);

	// Configuration registers
	logic [PW-1:0]               pwm_period_q, frame_interval_q, max_level_q;
	logic [PW-1:0]               pattern_interval_q;
	logic [lfp_pkg::MIN_W-1:0]   min_level_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pwm_period_q       <= lfp_pkg::PWM_PERIOD_RST;
			frame_interval_q   <= lfp_pkg::FRAME_INTERVAL_RST;
			max_level_q        <= lfp_pkg::MAX_LEVEL_RST;
			min_level_q        <= lfp_pkg::MIN_LEVEL_RST;
			pattern_interval_q <= lfp_pkg::PATTERN_INTERVAL_RST;
		end else if (cfg_we) begin
			unique case (lfp_pkg::reg_idx_t'(cfg_index))
				lfp_pkg::REG_PWM_PERIOD:       pwm_period_q       <= cfg_data;
				lfp_pkg::REG_FRAME_INTERVAL:   frame_interval_q   <= cfg_data;
				lfp_pkg::REG_MAX_LEVEL:        max_level_q        <= cfg_data;
				lfp_pkg::REG_MIN_LEVEL:        min_level_q        <= cfg_data[lfp_pkg::MIN_W-1:0];
				lfp_pkg::REG_PATTERN_INTERVAL: pattern_interval_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Input register
	logic                             valid_s1;
	lfp_pkg::cmd_t                    cmd_s1;
	logic [lfp_pkg::IDX_IN_W-1:0]     idx_s1;
	logic [lfp_pkg::MASK_W-1:0]       mask_s1;
	logic                             adv;

	assign adv      = valid_s1 && (!m_tvalid || m_tready);
	assign s_tready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			cmd_s1  <= lfp_pkg::cmd_t'(s_tuser);
			idx_s1  <= s_tdata[lfp_pkg::IDX_IN_W-1:0];
			mask_s1 <= s_tdata[lfp_pkg::IDX_IN_W +: lfp_pkg::MASK_W];
		end
	end

	// Block state
	logic [PW-1:0]               period_count_q, fade_cd_q, pat_cd_q;
	logic [LEVEL_BITS-1:0]       level_q [CHANNELS];
	logic [CHANNELS-1:0]         rising_q, led_q;
	logic                        fade_pend_q, chg_pend_q;
	logic [IDX_W-1:0]            pattern_index_q;
	logic [lfp_pkg::MASK_W-1:0]  active_mask_q;

	logic [PW-1:0]               period_n, fade_cd_n, pat_cd_n, cnt_inc, max_clamp;
	logic [LEVEL_BITS-1:0]       level_n [CHANNELS];
	logic [CHANNELS-1:0]         rising_n, led_n;
	logic                        fade_pend_n, chg_pend_n;
	logic [IDX_W-1:0]            index_n;
	logic [lfp_pkg::MASK_W-1:0]  mask_n;
	logic [LEVEL_BITS-1:0]       lo, hi;

	lfp_pkg::table_rd_t          tbl;
	lfp_pkg::fade_ctl_t          fctl;
	logic [LEVEL_BITS-1:0]       lvl_f [CHANNELS];
	logic [CHANNELS-1:0]         rise_f;
	logic [lfp_pkg::MASK_W-1:0]  mask_f;

	lfp_pattern_table #(
		.PATTERN_DEPTH (PATTERN_DEPTH),
		.IDX_W         (IDX_W)
	) u_table (
		.clk     (clk),
		.arst_n  (arst_n),
		.we      (adv && (cmd_s1 == lfp_pkg::CMD_WRITE_ENTRY)),
		.wr_idx  (idx_s1),
		.wr_mask (mask_s1),
		.rd_idx  (pattern_index_q),
		.rd      (tbl)
	);

	lfp_fade #(
		.CHANNELS   (CHANNELS),
		.LEVEL_BITS (LEVEL_BITS)
	) u_fade (
		.level          (level_q),
		.rising         (rising_q),
		.active_mask    (active_mask_q),
		.change_pending (chg_pend_q),
		.lo             (lo),
		.hi             (hi),
		.tbl            (tbl),
		.level_nxt      (lvl_f),
		.rising_nxt     (rise_f),
		.mask_nxt       (mask_f),
		.ctl            (fctl)
	);

	// Effective fade limits
	always_comb begin
		lo        = (min_level_q == '0) ? LEVEL_BITS'(1) : LEVEL_BITS'(min_level_q);
		max_clamp = (max_level_q > pwm_period_q) ? pwm_period_q : max_level_q;
		hi        = (max_clamp > LevelTop) ? LEVEL_BITS'(LevelTop) : LEVEL_BITS'(max_clamp);
	end

	always_comb begin
		period_n    = period_count_q;
		fade_cd_n   = fade_cd_q;
		pat_cd_n    = pat_cd_q;
		level_n     = level_q;
		rising_n    = rising_q;
		led_n       = led_q;
		fade_pend_n = fade_pend_q;
		chg_pend_n  = chg_pend_q;
		index_n     = pattern_index_q;
		mask_n      = active_mask_q;
		cnt_inc     = period_count_q + 1'b1;
		if (adv) begin
			unique case (cmd_s1)
				lfp_pkg::CMD_PWM_STEP: begin
					period_n = cnt_inc;
					if (cnt_inc == pwm_period_q) begin
						period_n = '0;
						led_n    = '1;
						if (fade_pend_q) begin
							fade_pend_n = 1'b0;
							level_n     = lvl_f;
							rising_n    = rise_f;
							mask_n      = mask_f;
							if (fctl.advance) begin
								chg_pend_n = 1'b0;
								index_n    = pattern_index_q + 1'b1;
							end
							if (fctl.restart) begin
								index_n   = '0;
								fade_cd_n = frame_interval_q;
								pat_cd_n  = pattern_interval_q;
							end
						end
					end
					for (int j = 0; j < CHANNELS; j++) begin
						if (period_n == PW'(level_n[j])) begin
							led_n[j] = 1'b0;
						end
					end
				end
				lfp_pkg::CMD_FRAME_TICK: begin
					if (fade_cd_q != '0) begin
						fade_cd_n = fade_cd_q - 1'b1;
					end else begin
						fade_cd_n   = frame_interval_q;
						fade_pend_n = 1'b1;
						if (pat_cd_q != '0) begin
							pat_cd_n = pat_cd_q - 1'b1;
						end else begin
							pat_cd_n   = pattern_interval_q;
							chg_pend_n = 1'b1;
						end
					end
				end
				lfp_pkg::CMD_WRITE_ENTRY: ;
				lfp_pkg::CMD_RESTART: begin
					period_n  = '0;
					fade_cd_n = frame_interval_q;
					pat_cd_n  = pattern_interval_q;
					index_n   = '0;
					mask_n    = tbl.entry0;
					rising_n  = '0;
					for (int j = 0; j < CHANNELS; j++) begin
						level_n[j] = lo;
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_count_q  <= '0;
			fade_cd_q       <= lfp_pkg::FRAME_INTERVAL_RST;
			pat_cd_q        <= lfp_pkg::PATTERN_INTERVAL_RST;
			for (int j = 0; j < CHANNELS; j++) begin
				level_q[j] <= LEVEL_BITS'(lfp_pkg::MIN_LEVEL_RST);
			end
			rising_q        <= '0;
			led_q           <= '0;
			fade_pend_q     <= 1'b0;
			chg_pend_q      <= 1'b0;
			pattern_index_q <= '0;
			active_mask_q   <= lfp_pkg::default_entry(0);
		end else begin
			period_count_q  <= period_n;
			fade_cd_q       <= fade_cd_n;
			pat_cd_q        <= pat_cd_n;
			level_q         <= level_n;
			rising_q        <= rising_n;
			led_q           <= led_n;
			fade_pend_q     <= fade_pend_n;
			chg_pend_q      <= chg_pend_n;
			pattern_index_q <= index_n;
			active_mask_q   <= mask_n;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (adv) begin
			m_tvalid <= 1'b1;
		end else if (m_tready) begin
			m_tvalid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			m_tdata <= lfp_pkg::DATA_W'({lfp_pkg::POS_W'(index_n), lfp_pkg::LED_W'(led_n)});
		end
	end

	`LFP_ASSERT(a_index_range, 1'b1, 32'(pattern_index_q) < PATTERN_DEPTH, "pattern index out of range")
	`LFP_ASSERT_NEXT(a_restart_clears, adv && (cmd_s1 == lfp_pkg::CMD_RESTART), (pattern_index_q == '0) && (period_count_q == '0), "restart left sequencer state")
	`LFP_ASSERT_NEXT(a_fade_consumed, adv && (cmd_s1 == lfp_pkg::CMD_PWM_STEP) && (cnt_inc == pwm_period_q), !fade_pend_q && (period_count_q == '0), "period end did not consume fade request")
	`LFP_ASSERT_NEXT(a_result_loaded, adv, m_tvalid, "processed command gave no result")

endmodule

>>> verif/six_channel_led_fade_pwm_core_tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// six_channel_led_fade_pwm_core_tb
// Self-checking bench for the LED fade PWM core. It drives command transfers
// on the input stream, predicts the LED bits and the pattern position after
// each command, and compares every output transfer with the oldest prediction.
// Both stream sides idle at random, and the run covers several register settings.
// ---------------------------------------------------------------------------
module six_channel_led_fade_pwm_core_tb;

	localparam int STALL_LIMIT = 5000;
	localparam int RX_HOLD_CYCLES = 300;
	localparam int ZERO_PERIOD_STEPS = 60;

	typedef struct packed {
		logic [lfp_pkg::LED_W-1:0] led_on;
		logic [lfp_pkg::POS_W-1:0] position;
	} led_view_t;

	logic                          clk = 1'b0;
	logic                          arst_n = 1'b0;
	logic                          s_tvalid = 1'b0;
	logic                          s_tready;
	// entry_index[3:0], entry_mask[9:4]
	logic [lfp_pkg::DATA_W-1:0]    s_tdata = '0;
	// cmd[1:0]
	logic [lfp_pkg::CMD_W-1:0]     s_tuser = lfp_pkg::CMD_PWM_STEP;
	logic                          m_tvalid;
	logic                          m_tready = 1'b0;
	// led_on[5:0], pattern_position[9:6]
	logic [lfp_pkg::DATA_W-1:0]    m_tdata;
	logic                          cfg_we = 1'b0;
	logic [lfp_pkg::CFG_IDX_W-1:0] cfg_index = lfp_pkg::REG_PWM_PERIOD;
	logic [lfp_pkg::CFG_W-1:0]     cfg_data = '0;

	// Shadow copy of the registers and of the sequencer state.
	logic [15:0] shadow_period, shadow_frame, shadow_max, shadow_seq_gap;
	logic [7:0]  shadow_min;
	logic [15:0] shadow_count;
	int unsigned shadow_level [lfp_pkg::CHANNELS_DEF];
	logic [5:0]  shadow_rising;
	logic [5:0]  shadow_leds;
	logic [15:0] shadow_fade_cd, shadow_seq_cd;
	logic        shadow_fade_due, shadow_change_due;
	int unsigned shadow_pos;
	logic [5:0]  shadow_mask;
	logic [5:0]  shadow_table [lfp_pkg::PATTERN_DEPTH_DEF];

	led_view_t pending_views [$];

	int  mismatch_count = 0;
	int  sent_count = 0;
	int  checked_count = 0;
	int  period_ends = 0;
	int  seq_advances = 0;
	int  seq_restarts = 0;
	int  rx_hold = 0;
	bit  burst = 1'b0;

	six_channel_led_fade_pwm_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	function automatic int unsigned floor_level();
		return (shadow_min == 8'd0) ? 1 : int'(shadow_min);
	endfunction

	function automatic void sequence_restart();
		shadow_fade_cd = shadow_frame;
		shadow_seq_cd  = shadow_seq_gap;
		shadow_pos     = 0;
		shadow_mask    = shadow_table[0];
		shadow_count   = '0;
		for (int ch = 0; ch < lfp_pkg::CHANNELS_DEF; ch++) begin
			shadow_level[ch]  = floor_level();
			shadow_rising[ch] = 1'b0;
		end
		seq_restarts++;
	endfunction

	function automatic void shadow_reset();
		shadow_period  = lfp_pkg::PWM_PERIOD_RST;
		shadow_frame   = lfp_pkg::FRAME_INTERVAL_RST;
		shadow_max     = lfp_pkg::MAX_LEVEL_RST;
		shadow_min     = lfp_pkg::MIN_LEVEL_RST;
		shadow_seq_gap = lfp_pkg::PATTERN_INTERVAL_RST;
		shadow_table = '{6'h09, 6'h12, 6'h24, 6'h1B, 6'h1E, 6'h36, 6'h2D, 6'h3F,
			6'h21, 6'h14, 6'h0C, 6'h33, 6'h00, 6'h00, 6'h00, 6'h00};
		shadow_leds       = '0;
		shadow_fade_due   = 1'b0;
		shadow_change_due = 1'b0;
		sequence_restart();
	endfunction

	// Applies one command to the shadow state and returns what the core shows after it.
	function automatic led_view_t fade_pwm_next(lfp_pkg::cmd_t c, logic [3:0] idx,
			logic [5:0] msk);
		int unsigned lo, hi;
		led_view_t view;
		case (c)
			lfp_pkg::CMD_PWM_STEP: begin
				shadow_count = shadow_count + 16'd1;
				if (shadow_count == shadow_period) begin
					shadow_count = '0;
					shadow_leds  = '1;
					period_ends++;
					if (shadow_fade_due) begin
						shadow_fade_due = 1'b0;
						for (int ch = 0; ch < lfp_pkg::CHANNELS_DEF; ch++) begin
							lo = floor_level();
							hi = (shadow_max > shadow_period) ? 32'(shadow_period)
								: 32'(shadow_max);
							if (shadow_mask[ch]) begin
								if (shadow_rising[ch]) begin
									if (shadow_level[ch] < 32'hFFFF)
										shadow_level[ch]++;
									if (shadow_level[ch] >= hi) begin
										shadow_level[ch]  = hi;
										shadow_rising[ch] = 1'b0;
									end
								end else begin
									if (shadow_level[ch] > 0)
										shadow_level[ch]--;
									if (shadow_level[ch] <= lo) begin
										shadow_level[ch]  = lo;
										shadow_rising[ch] = 1'b1;
										if (shadow_change_due) begin
											shadow_change_due = 1'b0;
											shadow_pos++;
											seq_advances++;
											// A restart here leaves the later channels
											// of this step to run under entry zero.
											if (shadow_pos >= lfp_pkg::PATTERN_DEPTH_DEF ||
												shadow_table[shadow_pos] == 6'd0)
												sequence_restart();
											else
												shadow_mask = shadow_table[shadow_pos];
										end
									end
								end
							end else begin
								shadow_level[ch] = lo;
							end
						end
					end
				end
				for (int ch = 0; ch < lfp_pkg::CHANNELS_DEF; ch++)
					if (32'(shadow_count) == shadow_level[ch])
						shadow_leds[ch] = 1'b0;
			end
			lfp_pkg::CMD_FRAME_TICK: begin
				if (shadow_fade_cd > 0) begin
					shadow_fade_cd--;
				end else begin
					shadow_fade_cd  = shadow_frame;
					shadow_fade_due = 1'b1;
					if (shadow_seq_cd > 0) begin
						shadow_seq_cd--;
					end else begin
						shadow_seq_cd     = shadow_seq_gap;
						shadow_change_due = 1'b1;
					end
				end
			end
			lfp_pkg::CMD_WRITE_ENTRY: shadow_table[idx] = msk;
			lfp_pkg::CMD_RESTART:     sequence_restart();
			default: ;
		endcase
		view.led_on   = shadow_leds;
		view.position = shadow_pos[3:0];
		return view;
	endfunction

	// One command transfer, preceded by a random gap unless in burst mode.
	task automatic send_cmd(lfp_pkg::cmd_t c, logic [3:0] idx, logic [5:0] msk);
		int gap;
		gap = burst ? 0 : $urandom_range(0, 6);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= c;
		s_tdata  <= {6'd0, msk, idx};
		do @(posedge clk); while (!s_tready);
		pending_views.push_back(fade_pwm_next(c, idx, msk));
		sent_count++;
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		while (pending_views.size() != 0) @(posedge clk);
		repeat (3) @(posedge clk);
	endtask

	task automatic program_regs(input logic [15:0] period, frame, max_lvl, min_lvl, seq_gap);
		logic [15:0] vals [5];
		vals[0] = period;
		vals[1] = frame;
		vals[2] = max_lvl;
		vals[3] = min_lvl;
		vals[4] = seq_gap;
		for (int i = 0; i < 5; i++) begin
			cfg_we    <= 1'b1;
			cfg_index <= lfp_pkg::reg_idx_t'(i);
			cfg_data  <= vals[i];
			@(posedge clk);
			case (lfp_pkg::reg_idx_t'(i))
				lfp_pkg::REG_PWM_PERIOD:       shadow_period  = vals[i];
				lfp_pkg::REG_FRAME_INTERVAL:   shadow_frame   = vals[i];
				lfp_pkg::REG_MAX_LEVEL:        shadow_max     = vals[i];
				lfp_pkg::REG_MIN_LEVEL:        shadow_min     = vals[i][7:0];
				lfp_pkg::REG_PATTERN_INTERVAL: shadow_seq_gap = vals[i];
				default: ;
			endcase
		end
		cfg_we <= 1'b0;
		repeat (2) @(posedge clk);
	endtask

	// Mostly PWM steps and frame ticks, so that fades and pattern changes happen,
	// with a few table writes and restarts mixed in.
	task automatic send_random(int n);
		int pick;
		lfp_pkg::cmd_t c;
		logic [5:0] msk;
		for (int k = 0; k < n; k++) begin
			pick = $urandom_range(0, 99);
			if (pick < 68)
				c = lfp_pkg::CMD_PWM_STEP;
			else if (pick < 90)
				c = lfp_pkg::CMD_FRAME_TICK;
			else if (pick < 97)
				c = lfp_pkg::CMD_WRITE_ENTRY;
			else
				c = lfp_pkg::CMD_RESTART;
			msk = ($urandom_range(0, 5) == 0) ? 6'h00 : 6'($urandom_range(1, 63));
			send_cmd(c, 4'($urandom_range(0, 15)), msk);
		end
	endtask

	task automatic test_reset_state();
		send_cmd(lfp_pkg::CMD_PWM_STEP, 4'h0, 6'h00);
		send_cmd(lfp_pkg::CMD_FRAME_TICK, 4'hF, 6'h3F);
		send_cmd(lfp_pkg::CMD_PWM_STEP, 4'h5, 6'h2A);
		send_cmd(lfp_pkg::CMD_FRAME_TICK, 4'hA, 6'h15);
		send_cmd(lfp_pkg::CMD_PWM_STEP, 4'h0, 6'h00);
		send_cmd(lfp_pkg::CMD_PWM_STEP, 4'hF, 6'h3F);
		drain();
	endtask

	task automatic test_directed_cases();
		// Maximum well above the period, so the fade top is clamped to it.
		program_regs(16'd3, 16'd0, 16'hFFFF, 16'd1, 16'd0);
		// Fill the tail of the table so that the sequence can run past its end.
		send_cmd(lfp_pkg::CMD_WRITE_ENTRY, 4'hF, 6'h3F);
		send_cmd(lfp_pkg::CMD_WRITE_ENTRY, 4'hC, 6'h01);
		send_cmd(lfp_pkg::CMD_WRITE_ENTRY, 4'hD, 6'h20);
		send_cmd(lfp_pkg::CMD_WRITE_ENTRY, 4'hE, 6'h2A);
		// An empty first entry holds every channel at the minimum.
		send_cmd(lfp_pkg::CMD_WRITE_ENTRY, 4'h0, 6'h00);
		send_cmd(lfp_pkg::CMD_RESTART, 4'h0, 6'h00);
		repeat (3) send_cmd(lfp_pkg::CMD_PWM_STEP, 4'h0, 6'h00);
		send_cmd(lfp_pkg::CMD_WRITE_ENTRY, 4'h0, 6'h3F);
		send_cmd(lfp_pkg::CMD_RESTART, 4'hF, 6'h3F);
		send_cmd(lfp_pkg::CMD_FRAME_TICK, 4'h0, 6'h00);
		repeat (4) send_cmd(lfp_pkg::CMD_PWM_STEP, 4'hF, 6'h3F);
		send_cmd(lfp_pkg::CMD_FRAME_TICK, 4'h0, 6'h00);
		repeat (3) send_cmd(lfp_pkg::CMD_PWM_STEP, 4'h0, 6'h00);
		drain();
	endtask

	task automatic test_fast_sequencing();
		program_regs(16'd4, 16'd0, 16'd3, 16'd1, 16'd0);
		send_random(350);
		drain();
	endtask

	task automatic test_level_clamping();
		program_regs(16'd8, 16'd2, 16'hFFFF, 16'd3, 16'd2);
		send_random(150);
		drain();
		// Raising the minimum leaves some levels below it until they climb past it or next fall.
		program_regs(16'd8, 16'd2, 16'hFFFF, 16'd6, 16'd2);
		send_random(100);
		drain();
		// A zero minimum acts as one.
		program_regs(16'd6, 16'd0, 16'd5, 16'd0, 16'd1);
		send_random(150);
		drain();
	endtask

	task automatic test_register_extremes();
		program_regs(16'd1, 16'd0, 16'd0, 16'd255, 16'd0);
		send_random(100);
		drain();
		program_regs(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd255, 16'hFFFF);
		send_random(100);
		drain();
	endtask

	task automatic test_output_stall();
		program_regs(16'd5, 16'd0, 16'd4, 16'd1, 16'd1);
		rx_hold = RX_HOLD_CYCLES;
		send_random(60);
		drain();
		send_random(150);
		drain();
	endtask

	// With a zero period the counter only ends a period when it wraps at 16 bits,
	// so a short back-to-back run must see no period end at all.
	task automatic test_zero_period();
		burst = 1'b1;
		program_regs(16'd0, 16'd0, 16'd40, 16'd2, 16'd0);
		send_cmd(lfp_pkg::CMD_RESTART, 4'h0, 6'h00);
		for (int i = 0; i < ZERO_PERIOD_STEPS; i++)
			send_cmd((i == 7) ? lfp_pkg::CMD_FRAME_TICK : lfp_pkg::CMD_PWM_STEP,
				4'($urandom_range(0, 15)), 6'($urandom_range(0, 63)));
		burst = 1'b0;
		drain();
	endtask

	task automatic test_random_mix();
		program_regs(16'd3, 16'd1, 16'd2, 16'd1, 16'd3);
		send_random(110);
		drain();
	endtask

	initial begin
		shadow_reset();
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_state();
		test_directed_cases();
		test_fast_sequencing();
		test_level_clamping();
		test_register_extremes();
		test_output_stall();
		test_zero_period();
		test_random_mix();
		drain();
		repeat (4) @(posedge clk);
		$display("%0d commands sent, %0d results checked, %0d mismatches",
			sent_count, checked_count, mismatch_count);
		$display("%0d period ends, %0d pattern advances, %0d sequence restarts",
			period_ends, seq_advances, seq_restarts);
		if (mismatch_count == 0)
			$display("six_channel_led_fade_pwm_core_tb: clean");
		else
			$display("six_channel_led_fade_pwm_core_tb: errors");
		$finish;
	end

	// Output side: random stalls per result, plus one long hold-off on request.
	initial begin : result_checker
		int n;
		led_view_t want;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (rx_hold > 0) begin
				n = rx_hold;
				rx_hold = 0;
			end else begin
				n = burst ? 0 : $urandom_range(0, 6);
			end
			if (n > 0) begin
				m_tready <= 1'b0;
				repeat (n) @(posedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
			checked_count++;
			if (pending_views.size() == 0) begin
				$error("result transfer with no command outstanding: %h", m_tdata);
				mismatch_count++;
			end else begin
				want = pending_views.pop_front();
				if (m_tdata[5:0] !== want.led_on) begin
					$error("led_on: expected %h, got %h", want.led_on, m_tdata[5:0]);
					mismatch_count++;
				end
				if (m_tdata[9:6] !== want.position) begin
					$error("pattern_position: expected %0d, got %0d",
						want.position, m_tdata[9:6]);
					mismatch_count++;
				end
			end
		end
	end

	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < STALL_LIMIT) begin
			@(posedge clk);
			if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
				quiet = 0;
			else
				quiet++;
		end
		$display("six_channel_led_fade_pwm_core_tb: errors");
		$finish;
	end

endmodule
